// ----- hdl/adts_pkg.sv -----
// Shared types and constants for the ADTS frame encapsulator.
// Used by the front end, the command queue, the back end and the top level.
package adts_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [16:0] HDR_LEN_EXT   = 17'd7;
    localparam logic [16:0] MAX_FRAME_LEN = 17'h1FFF;
    localparam logic [2:0]  HDR_LAST      = 3'd6;
    localparam logic [7:0]  HDR_SYNC_HI   = 8'hFF;
    localparam logic [7:0]  HDR_SYNC_LO   = 8'hF1;
    localparam logic [7:0]  HDR_TAIL      = 8'hFC;
    localparam logic [4:0]  FULLNESS_HI   = 5'h1F;
    localparam logic [3:0]  FREQ_INVALID  = 4'hF;

    // configuration register indexes
    localparam logic [1:0] REG_OBJECT_TYPE     = 2'd0;
    localparam logic [1:0] REG_FREQUENCY_INDEX = 2'd1;
    localparam logic [1:0] REG_CHANNEL_SETTING = 2'd2;

    localparam logic [4:0] OBJECT_TYPE_RST     = 5'd2;
    localparam logic [3:0] FREQUENCY_INDEX_RST = 4'd4;
    localparam logic [3:0] CHANNEL_SETTING_RST = 4'd2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LONG   = 3'd1,
        ST_BAD_CONFIG = 3'd2,
        ST_STRAY      = 3'd3,
        ST_TRUNCATED  = 3'd4
    } t_status;

    typedef enum logic {
        KIND_SINGLE = 1'b0,
        KIND_HEADER = 1'b1
    } t_kind;

    // One queued command: a single result, or a seven-byte header expansion.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        t_status     status;
        logic [31:0] hdr_mid;   // header bytes 2..5, byte 2 in the low bits
    } t_cmd;

    typedef struct packed {
        logic [4:0] object_type;
        logic [3:0] frequency_index;
        logic [3:0] channel_setting;
    } t_cfg;

endpackage

// ----- hdl/adts_front.sv -----
// Front end: accepts input items, tracks frame state, classifies each item.
// Produces one queued command per item that yields results. Uses adts_pkg.
module adts_front
    import adts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_op         i_op,
    input  logic [15:0] i_size,
    input  logic [7:0]  i_byte,
    input  t_cfg        i_cfg,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_frame_open, n_frame_open;
    logic        r_frame_dropped, n_frame_dropped;

    logic [16:0] full_len;
    logic        too_long;
    logic        bad_cfg;
    logic [1:0]  prof;
    logic [15:0] left_dec;
    logic        emit;

    always_comb begin
        full_len = {1'b0, i_size} + HDR_LEN_EXT;
        too_long = full_len > MAX_FRAME_LEN;
        bad_cfg  = (i_cfg.frequency_index == FREQ_INVALID) || (i_cfg.channel_setting == 4'd0);
        prof     = (i_cfg.object_type == 5'd0) ? 2'd1 : (i_cfg.object_type[1:0] - 2'd1);
        left_dec = r_bytes_left - 16'd1;
    end

    always_comb begin
        n_bytes_left    = r_bytes_left;
        n_frame_open    = r_frame_open;
        n_frame_dropped = r_frame_dropped;
        emit            = 1'b0;
        o_cmd.kind      = KIND_SINGLE;
        o_cmd.data      = 8'd0;
        o_cmd.last      = 1'b0;
        o_cmd.status    = ST_OK;
        o_cmd.hdr_mid   = {
            full_len[2:0], FULLNESS_HI,
            full_len[10:3],
            i_cfg.channel_setting[1:0], 4'd0, full_len[12:11],
            prof, i_cfg.frequency_index, 1'b0, i_cfg.channel_setting[2]
        };
        case (i_op)
            OP_START: begin
                emit         = 1'b1;
                n_bytes_left = i_size;
                n_frame_open = (i_size != 16'd0);
                if (r_frame_open && !r_frame_dropped && (r_bytes_left != 16'd0)) begin
                    o_cmd.status    = ST_TRUNCATED;
                    n_frame_dropped = (i_size != 16'd0);
                end else if (too_long || bad_cfg) begin
                    o_cmd.status    = too_long ? ST_TOO_LONG : ST_BAD_CONFIG;
                    n_frame_dropped = (i_size != 16'd0);
                end else begin
                    o_cmd.kind      = KIND_HEADER;
                    o_cmd.last      = (i_size == 16'd0);
                    n_frame_dropped = 1'b0;
                end
            end
            OP_BYTE: begin
                if (!r_frame_open || (r_bytes_left == 16'd0)) begin
                    emit            = 1'b1;
                    o_cmd.status    = ST_STRAY;
                    n_frame_open    = 1'b0;
                    n_frame_dropped = 1'b0;
                    n_bytes_left    = 16'd0;
                end else begin
                    n_bytes_left = left_dec;
                    if (left_dec == 16'd0) begin
                        n_frame_open    = 1'b0;
                        n_frame_dropped = 1'b0;
                    end
                    // drop bytes of a rejected frame silently
                    emit       = !r_frame_dropped;
                    o_cmd.data = i_byte;
                    o_cmd.last = (left_dec == 16'd0);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        o_push = i_accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left    <= 16'd0;
            r_frame_open    <= 1'b0;
            r_frame_dropped <= 1'b0;
        end else if (i_accept) begin
            r_bytes_left    <= n_bytes_left;
            r_frame_open    <= n_frame_open;
            r_frame_dropped <= n_frame_dropped;
        end
    end

endmodule

// ----- hdl/adts_queue.sv -----
// Command queue between the front end and the back end.
// Small circular buffer of t_cmd entries from adts_pkg.
module adts_queue
    import adts_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_cmd            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;

    assign o_full  = (r_count == CntFull);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hdl/adts_back.sv -----
// Back end: expands queued commands into output items, one per cycle unless
// the output stalls. A header gives seven items, others one. Uses adts_pkg.
module adts_back
    import adts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    input  logic       i_m_tready,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    output logic [2:0] o_m_tuser
);

    logic       r_tvalid, n_tvalid;
    logic [7:0] r_tdata, n_tdata;
    logic       r_tlast, n_tlast;
    t_status    r_tuser, n_tuser;
    logic [2:0] r_idx, n_idx;
    logic       load;

    assign load = !i_empty && (!r_tvalid || i_m_tready);

    always_comb begin
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;
        n_tuser  = r_tuser;
        n_idx    = r_idx;
        o_pop    = 1'b0;
        if (r_tvalid && i_m_tready) begin
            n_tvalid = 1'b0;
        end
        if (load) begin
            n_tvalid = 1'b1;
            n_tuser  = i_cmd.status;
            if (i_cmd.kind == KIND_HEADER) begin
                case (r_idx)
                    3'd0:    n_tdata = HDR_SYNC_HI;
                    3'd1:    n_tdata = HDR_SYNC_LO;
                    3'd2:    n_tdata = i_cmd.hdr_mid[7:0];
                    3'd3:    n_tdata = i_cmd.hdr_mid[15:8];
                    3'd4:    n_tdata = i_cmd.hdr_mid[23:16];
                    3'd5:    n_tdata = i_cmd.hdr_mid[31:24];
                    default: n_tdata = HDR_TAIL;
                endcase
                n_tlast = (r_idx == HDR_LAST) && i_cmd.last;
                // advance through the header, pop after the last header byte
                if (r_idx == HDR_LAST) begin
                    o_pop = 1'b1;
                    n_idx = 3'd0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end else begin
                n_tdata = i_cmd.data;
                n_tlast = i_cmd.last;
                o_pop   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= 3'd0;
        end else begin
            r_tvalid <= n_tvalid;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
        r_tuser <= n_tuser;
    end

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;
    assign o_m_tuser  = r_tuser;

endmodule

// ----- hdl/adts_frame_encapsulator_unit.sv -----
// ADTS frame encapsulator: top level with configuration registers.
// Instantiates adts_front, adts_queue and adts_back; uses adts_pkg.
//
// Input stream: tuser is the op (0 frame start, 1 payload byte); tdata holds
// the payload size in bits 15:0 and the payload byte in bits 23:16.
// Output stream: tdata is the ADTS byte, tlast marks the last byte of a
// frame, tuser is the status (0 ok, 1 too long, 2 bad config, 3 stray byte,
// 4 truncated frame; tdata is 0 on an error item).
// An item's results pass through the command queue and then the output register.
// Throughput: one input item per cycle while the queue is not full; a
// good frame start occupies the output for seven header bytes, so the
// command queue fills and the input stalls until the header is out.
// Items of a dropped frame produce nothing and likewise pass at one per cycle.
// A stalled output holds its item; the front keeps accepting until the
// queue is full. Reset clears the frame state, the queue and the output
// valid, and loads the register defaults (object type 2, frequency index 4,
// channel configuration 2). Registers are written over APB at 0x0, 0x4, 0x8.
module adts_frame_encapsulator_unit
    import adts_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] frame_size, [23:16] payload_byte
    input  logic        i_s_tuser,   // [0] op
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,
    output logic [2:0]  o_m_tuser,   // [2:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    logic cfg_wr;
    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.object_type     <= OBJECT_TYPE_RST;
            r_cfg.frequency_index <= FREQUENCY_INDEX_RST;
            r_cfg.channel_setting <= CHANNEL_SETTING_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OBJECT_TYPE:     r_cfg.object_type     <= pwdata[4:0];
                REG_FREQUENCY_INDEX: r_cfg.frequency_index <= pwdata[3:0];
                REG_CHANNEL_SETTING: r_cfg.channel_setting <= pwdata[3:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OBJECT_TYPE:     prdata = {27'd0, r_cfg.object_type};
            REG_FREQUENCY_INDEX: prdata = {28'd0, r_cfg.frequency_index};
            REG_CHANNEL_SETTING: prdata = {28'd0, r_cfg.channel_setting};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    adts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (t_op'(i_s_tuser)),
        .i_size   (i_s_tdata[15:0]),
        .i_byte   (i_s_tdata[23:16]),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    adts_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    adts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ----- test/adts_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the ADTS frame encapsulator: tracks APB writes, predicts the
// ADTS byte stream for every accepted input item and checks each output item.
// Depends on adts_pkg.
module adts_checker
    import adts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] frame_size, [23:16] payload_byte
    input  logic        i_s_tuser,   // [0] op
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [7:0] out_byte
    input  logic        i_m_tlast,
    input  logic [2:0]  i_m_tuser,   // [2:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_adts_byte;

    t_adts_byte  adts_stream_q[$];
    t_cfg        cfg;
    logic [15:0] bytes_left;
    logic        frame_open;
    logic        frame_dropped;
    int          errors = 0;

    function automatic void push_byte(logic [7:0] data, logic last, t_status status);
        t_adts_byte entry;
        entry = '{data, last, status};
        adts_stream_q = {adts_stream_q, entry};
    endfunction

    function automatic void encapsulate_item(t_op op, logic [15:0] size, logic [7:0] data);
        logic [16:0] full;
        logic [4:0]  prof;
        logic [7:0]  hdr [7];
        logic        good;
        full = {1'b0, size} + HDR_LEN_EXT;
        prof = (cfg.object_type != 5'd0) ? cfg.object_type - 5'd1 : 5'd1;
        if (op == OP_START) begin
            good = 1'b0;
            if (frame_open && !frame_dropped && bytes_left != 16'd0) begin
                push_byte(8'h00, 1'b0, ST_TRUNCATED);
            end else if (full > MAX_FRAME_LEN || cfg.frequency_index == FREQ_INVALID ||
                         cfg.channel_setting == 4'd0) begin
                push_byte(8'h00, 1'b0, (full > MAX_FRAME_LEN) ? ST_TOO_LONG : ST_BAD_CONFIG);
            end else begin
                good = 1'b1;
                hdr[0] = HDR_SYNC_HI;
                hdr[1] = HDR_SYNC_LO;
                hdr[2] = {prof[1:0], cfg.frequency_index, 1'b0, cfg.channel_setting[2]};
                hdr[3] = {cfg.channel_setting[1:0], 4'b0000, full[12:11]};
                hdr[4] = full[10:3];
                hdr[5] = {full[2:0], FULLNESS_HI};
                hdr[6] = HDR_TAIL;
                for (int i = 0; i < 7; i++)
                    push_byte(hdr[i], (i == HDR_LAST) && (size == 16'd0), ST_OK);
            end
            // a rejected frame stays open as dropped so its payload is eaten
            bytes_left    = size;
            frame_open    = (size != 16'd0);
            frame_dropped = good ? 1'b0 : (size != 16'd0);
        end else if (!frame_open || bytes_left == 16'd0) begin
            frame_open    = 1'b0;
            frame_dropped = 1'b0;
            bytes_left    = 16'd0;
            push_byte(8'h00, 1'b0, ST_STRAY);
        end else begin
            bytes_left = bytes_left - 16'd1;
            if (!frame_dropped)
                push_byte(data, bytes_left == 16'd0, ST_OK);
            if (bytes_left == 16'd0) begin
                frame_open    = 1'b0;
                frame_dropped = 1'b0;
            end
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_adts_byte want;
        if (!i_rst_n) begin
            cfg.object_type     = OBJECT_TYPE_RST;
            cfg.frequency_index = FREQUENCY_INDEX_RST;
            cfg.channel_setting = CHANNEL_SETTING_RST;
            bytes_left          = 16'd0;
            frame_open          = 1'b0;
            frame_dropped       = 1'b0;
            adts_stream_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (adts_stream_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got data %h last %b status %0d",
                             $time, i_m_tdata, i_m_tlast, i_m_tuser);
                end else begin
                    want = adts_stream_q.pop_front();
                    if (i_m_tdata !== want.data) begin
                        errors++;
                        $display("%0t: out_byte expected %h, got %h", $time, want.data, i_m_tdata);
                    end
                    if (i_m_tlast !== want.last) begin
                        errors++;
                        $display("%0t: frame_end expected %b, got %b", $time, want.last, i_m_tlast);
                    end
                    if (i_m_tuser !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d", $time, want.status, i_m_tuser);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_OBJECT_TYPE:     cfg.object_type     = pwdata[4:0];
                    REG_FREQUENCY_INDEX: cfg.frequency_index = pwdata[3:0];
                    REG_CHANNEL_SETTING: cfg.channel_setting = pwdata[3:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                encapsulate_item(t_op'(i_s_tuser), i_s_tdata[15:0], i_s_tdata[23:16]);
        end
        o_errors  <= errors;
        o_pending <= adts_stream_q.size();
    end

endmodule

// ----- test/tb_adts_frame_encapsulator_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for adts_frame_encapsulator_unit: drives frames, payload bytes,
// APB register writes and output back-pressure; adts_checker does the checking.
// Depends on adts_pkg, adts_checker and the block under test.
module tb_adts_frame_encapsulator_unit;
    import adts_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 22;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;
    logic        i_s_tuser  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic [2:0]  o_m_tuser;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    int          chk_errors;
    int          chk_pending;
    int unsigned cycle_count = 0;
    bit          quiet       = 1'b0;
    bit          hold_armed  = 1'b0;
    bit          hold_served = 1'b0;

    always #5 i_clk = ~i_clk;

    adts_frame_encapsulator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    adts_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tlast  (o_m_tlast),
        .i_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input t_op op, input logic [15:0] size, input logic [7:0] data);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {data, size};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        gap = idle_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every predicted item is out, plus a margin for dropped payload
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] obj, input logic [3:0] freq,
                              input logic [3:0] chan);
        drain();
        write_reg(REG_OBJECT_TYPE, {27'd0, obj});
        write_reg(REG_FREQUENCY_INDEX, {28'd0, freq});
        write_reg(REG_CHANNEL_SETTING, {28'd0, chan});
    endtask

    task automatic directed_items();
        send_item(OP_BYTE, 16'h0000, 8'h5A);    // stray byte right after reset
        send_item(OP_START, 16'h0000, 8'h00);   // header only
        send_item(OP_START, 16'h0002, 8'hFF);
        send_item(OP_BYTE, 16'hFFFF, 8'h00);
        send_item(OP_BYTE, 16'h0000, 8'hFF);
        // restart while a good frame still waits for payload
        send_item(OP_START, 16'h0003, 8'h00);
        send_item(OP_BYTE, 16'h0000, 8'h12);
        send_item(OP_START, 16'h0001, 8'h00);
        send_item(OP_BYTE, 16'h0000, 8'h34);
        send_item(OP_START, 16'h1FF8, 8'h00);   // longest legal frame
        send_item(OP_START, 16'hFFFF, 8'h00);
        send_item(OP_START, 16'h1FF9, 8'h00);   // cuts a dropped frame, one too long
        send_item(OP_START, 16'hFFFF, 8'h00);
        send_item(OP_START, 16'h0001, 8'h00);
        send_item(OP_BYTE, 16'h0000, 8'hA5);
        send_item(OP_BYTE, 16'h0000, 8'hC3);    // stray after the frame closed
        set_config(5'd0, FREQ_INVALID, 4'd1);
        send_item(OP_START, 16'h0004, 8'h00);   // bad config, payload eaten
        repeat (4) send_item(OP_BYTE, 16'h0000, 8'($urandom));
        send_item(OP_BYTE, 16'h0000, 8'h77);
        send_item(OP_START, 16'hFFFF, 8'h00);   // too long wins over bad config
        set_config(5'd1, 4'd0, 4'd0);
        send_item(OP_START, 16'h0000, 8'h00);
    endtask

    task automatic random_phase(input int target);
        int count;
        int pick;
        int size;
        int nbytes;
        count = 0;
        while (count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // well-formed frame: start then exactly its payload
                pick = $urandom_range(0, 99);
                size = (pick < 10) ? 0 :
                       (pick < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                send_item(OP_START, 16'(size), 8'($urandom));
                count++;
                for (int k = 0; k < size; k++) begin
                    send_item(OP_BYTE, 16'($urandom), 8'($urandom));
                    count++;
                end
            end else if (pick < 78) begin
                send_item(OP_BYTE, 16'($urandom), 8'($urandom));
                count++;
            end else begin
                // leave the frame short; the next start cuts it off
                size   = $urandom_range(0, 65535);
                nbytes = $urandom_range(0, 3);
                send_item(OP_START, 16'(size), 8'($urandom));
                count++;
                for (int k = 0; k < nbytes && k < size; k++) begin
                    send_item(OP_BYTE, 16'($urandom), 8'($urandom));
                    count++;
                end
            end
        end
    endtask

    // output side: random back-pressure plus one long hold-off
    initial begin : sink
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_armed && !hold_served) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end
            n = idle_gap();
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(5'd0, 4'd0, 4'd1);
                1: set_config(5'd1, 4'd14, 4'd15);
                2: set_config(5'd31, FREQ_INVALID, 4'd7);
                3: set_config(5'd17, 4'd3, 4'd0);
                4: set_config(OBJECT_TYPE_RST, FREQUENCY_INDEX_RST, CHANNEL_SETTING_RST);
                default: set_config(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)));
            endcase
            quiet = (p == 1);
            if (p == 0)
                hold_armed = 1'b1;
            random_phase(PHASE_ITEMS);
        end
        drain();
        if (chk_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
